[hdl/arba_pkg.sv]
// ----------------------------------------------------------------------------
// Aligned region bitmap allocator: shared definitions
// Map geometry, field widths, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arba_pkg;

  // Map geometry
  localparam int MAP_BITS  = 1024;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = $clog2(MAP_WORDS);

  // Field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 10;
  localparam int ORD_W    = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;

  // Region span: start plus the longest region the order field can name
  localparam int SPAN_W = (1 << ORD_W) + 1;
  // Word counts for multi-word regions, with headroom for group + size
  localparam int GRP_W  = SPAN_W - BIT_W;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_FIND    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BUSY    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

endpackage

`default_nettype wire

[hdl/aligned_region_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// Aligned region bitmap allocator
// Sequence: an invalid region or unknown operation is answered straight
//   from the request decode; else map words are read in CHK and then
//   written in FILL. A find reads until it hits or runs out of map, an
//   allocate reads region words up to the first taken one, a release only
//   the first. One map word is read per cycle through the map RAM port.
// Throughput: one request at a time; busy is high from acceptance until the
//   strobe cycle, in which a new request may already be taken.
// Reset: synchronous; every map word reads as free at once, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aligned_region_bitmap_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [arba_pkg::OP_W-1:0]      in_operation,
  input  wire logic [arba_pkg::POS_W-1:0]     in_position,
  input  wire logic [arba_pkg::ORD_W-1:0]     in_region_order,
  // result strobe, cannot be stalled
  output logic                                out_valid,
  output arba_pkg::status_t                   out_status,
  output logic [arba_pkg::POS_W-1:0]          out_region_start,
  // map size register
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [arba_pkg::CFG_W-1:0]     cfg_map_bits_in_use
);

  import arba_pkg::*;

  localparam int SZ_W  = BIT_W + 1;           // in-word region size, up to WORD_BITS
  localparam int CMP_W = BIT_W + 2;           // offset + size within a word
  localparam int EW_W  = CFG_W - BIT_W;       // map size counted in whole words

  // Sequencer: CHK examines one map word per cycle and steers the next read,
  // FILL writes the chosen words back one per cycle.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_FILL
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [ORD_W-1:0]     ord_r, ord_nxt;
  logic                 large_r, large_nxt;
  logic                 set_r, set_nxt;
  logic [WIDX_W-1:0]    w_r, w_nxt;
  logic [WIDX_W-1:0]    grp_r, grp_nxt;
  logic [WIDX_W-1:0]    end_r, end_nxt;
  word_t                mask_r, mask_nxt;
  logic [POS_W-1:0]     start_r, start_nxt;
  logic [CFG_W-1:0]     lim_r;
  logic [MAP_WORDS-1:0] word_vld_r;
  logic                 rd_vld_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [POS_W-1:0]     out_region_start_r;

  // map RAM port
  logic                 ram_wr_en;
  word_t                ram_wr_data;
  logic                 ram_rd_en;
  logic [WIDX_W-1:0]    ram_rd_addr;
  word_t                ram_rd_data;
  word_t                rd_word;

  // request decode
  logic                 acc;
  logic [SPAN_W-1:0]    in_size;
  logic [SPAN_W-1:0]    in_end;
  logic [SPAN_W-1:0]    in_last;
  logic                 in_aligned;
  logic                 in_fits;
  logic                 in_large;
  word_t                in_mask;

  // in-word search
  logic [SZ_W-1:0]      ord_size;
  logic [BIT_W-1:0]     ord_lo;
  word_t                blk_mask;
  logic [CFG_W-1:0]     base;
  logic [CFG_W-1:0]     diff;
  logic [SZ_W-1:0]      room;
  word_t                cand;
  logic                 hit;
  logic [BIT_W-1:0]     hit_i;

  // multi-word group walk
  logic [GRP_W-1:0]     k;
  logic [WIDX_W-1:0]    k_lo;
  logic [WIDX_W-1:0]    g;
  logic [EW_W-1:0]      eff_words;
  logic                 in_range;
  logic [GRP_W-1:0]     next_g;
  logic                 next_ok;
  logic                 grp_last;

  // completion
  logic                 fin;
  status_t              fin_status;
  logic [POS_W-1:0]     fin_start;

  arba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (w_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // A word never written since reset reads as all free.
  assign rd_word = rd_vld_r ? ram_rd_data : '0;

  assign busy             = (state_r != S_IDLE);
  // Hold a map size write off while busy or while a request is being taken
  assign cfg_ready        = (state_r == S_IDLE) && !start;
  assign acc              = start && (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_start = out_region_start_r;

  // --------------------------------------------------------------------------
  // Request decode: region size, alignment and bound against the map size.
  // --------------------------------------------------------------------------
  always_comb begin
    in_size    = SPAN_W'(1) << in_region_order;
    in_end     = SPAN_W'(in_position) + in_size;
    in_last    = in_end - SPAN_W'(1);
    in_aligned = (in_position & POS_W'(in_size - SPAN_W'(1))) == '0;
    in_fits    = in_end <= SPAN_W'(lim_r);
    in_large   = in_region_order > ORD_W'(BIT_W);
    in_mask    = ~({WORD_BITS{1'b1}} << in_size) << in_position[BIT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // In-word search for regions no longer than a word: flag every aligned
  // block that is clear and ends inside the map, then take the lowest.
  // --------------------------------------------------------------------------
  always_comb begin
    ord_size = SZ_W'(1) << ord_r;
    ord_lo   = BIT_W'(ord_size - SZ_W'(1));
    blk_mask = ~({WORD_BITS{1'b1}} << ord_size);
    base     = CFG_W'({w_r, {BIT_W{1'b0}}});
    diff     = lim_r - base;
    if (lim_r <= base) begin
      room = '0;
    end else if (diff >= CFG_W'(WORD_BITS)) begin
      room = SZ_W'(WORD_BITS);
    end else begin
      room = diff[SZ_W-1:0];
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      cand[i] = ((BIT_W'(i) & ord_lo) == '0) &&
                (((rd_word >> i) & blk_mask) == '0) &&
                ((CMP_W'(i) + CMP_W'(ord_size)) <= CMP_W'(room));
    end
    hit   = |cand;
    hit_i = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_i = BIT_W'(i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Group walk for regions of several words: k words per aligned group.
  // --------------------------------------------------------------------------
  always_comb begin
    k         = GRP_W'(1) << (ord_r - ORD_W'(BIT_W));
    k_lo      = WIDX_W'(k - GRP_W'(1));
    g         = w_r & ~k_lo;
    eff_words = EW_W'(lim_r >> BIT_W);
    in_range  = (GRP_W'(g) + k) <= GRP_W'(eff_words);
    next_g    = GRP_W'(g) + k;
    next_ok   = next_g < GRP_W'(MAP_WORDS);
    grp_last  = (w_r & k_lo) == k_lo;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    ord_nxt     = ord_r;
    large_nxt   = large_r;
    set_nxt     = set_r;
    w_nxt       = w_r;
    grp_nxt     = grp_r;
    end_nxt     = end_r;
    mask_nxt    = mask_r;
    start_nxt   = start_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = w_r + WIDX_W'(1);
    ram_wr_en   = 1'b0;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_start   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt    = op_t'(in_operation);
          ord_nxt   = in_region_order;
          large_nxt = in_large;
          set_nxt   = (in_operation != OP_RELEASE);
          mask_nxt  = in_mask;
          grp_nxt   = in_position[BIT_W +: WIDX_W];
          end_nxt   = in_last[BIT_W +: WIDX_W];
          start_nxt = '0;
          case (in_operation)
            OP_FIND: begin
              // scan from the bottom of the map
              w_nxt       = '0;
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              state_nxt   = S_CHK;
            end
            OP_ALLOC, OP_RELEASE: begin
              if (in_aligned && in_fits) begin
                w_nxt       = in_position[BIT_W +: WIDX_W];
                ram_rd_en   = 1'b1;
                ram_rd_addr = in_position[BIT_W +: WIDX_W];
                state_nxt   = S_CHK;
              end else begin
                fin        = 1'b1;
                fin_status = ST_INVALID;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ST_INVALID;
            end
          endcase
        end
      end

      S_CHK: begin
        case (op_r)
          OP_FIND: begin
            if (!large_r) begin
              if (hit) begin
                // hold the word in the read register and patch it in FILL
                mask_nxt  = blk_mask << hit_i;
                start_nxt = {w_r, hit_i};
                end_nxt   = w_r;
                state_nxt = S_FILL;
              end else if ((w_r == WIDX_W'(MAP_WORDS - 1)) ||
                           (room < SZ_W'(WORD_BITS))) begin
                fin        = 1'b1;
                fin_status = ST_NOSPACE;
              end else begin
                w_nxt     = w_r + WIDX_W'(1);
                ram_rd_en = 1'b1;
              end
            end else begin
              if (!in_range) begin
                fin        = 1'b1;
                fin_status = ST_NOSPACE;
              end else if (rd_word != '0) begin
                // group taken: skip to the next aligned group
                if (next_ok) begin
                  w_nxt       = next_g[WIDX_W-1:0];
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = next_g[WIDX_W-1:0];
                end else begin
                  fin        = 1'b1;
                  fin_status = ST_NOSPACE;
                end
              end else if (grp_last) begin
                w_nxt     = g;
                end_nxt   = w_r;
                start_nxt = {g, {BIT_W{1'b0}}};
                state_nxt = S_FILL;
              end else begin
                w_nxt     = w_r + WIDX_W'(1);
                ram_rd_en = 1'b1;
              end
            end
          end

          OP_ALLOC: begin
            if (large_r) begin
              if (rd_word != '0) begin
                fin        = 1'b1;
                fin_status = ST_BUSY;
              end else if (w_r == end_r) begin
                w_nxt     = grp_r;
                state_nxt = S_FILL;
              end else begin
                w_nxt     = w_r + WIDX_W'(1);
                ram_rd_en = 1'b1;
              end
            end else if ((rd_word & mask_r) != '0) begin
              fin        = 1'b1;
              fin_status = ST_BUSY;
            end else begin
              state_nxt = S_FILL;
            end
          end

          OP_RELEASE: begin
            w_nxt     = grp_r;
            state_nxt = S_FILL;
          end

          default: begin
            fin        = 1'b1;
            fin_status = ST_INVALID;
          end
        endcase
      end

      S_FILL: begin
        ram_wr_en = 1'b1;
        if (w_r == end_r) begin
          fin       = 1'b1;
          fin_start = start_r;
        end else begin
          w_nxt = w_r + WIDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  // Whole words for multi-word regions, read-modify-write inside one word.
  always_comb begin
    if (large_r) begin
      ram_wr_data = {WORD_BITS{set_r}};
    end else if (set_r) begin
      ram_wr_data = rd_word | mask_r;
    end else begin
      ram_wr_data = rd_word & ~mask_r;
    end
  end

  // --------------------------------------------------------------------------
  // State and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    op_r               <= op_nxt;
    ord_r              <= ord_nxt;
    large_r            <= large_nxt;
    set_r              <= set_nxt;
    w_r                <= w_nxt;
    grp_r              <= grp_nxt;
    end_r              <= end_nxt;
    mask_r             <= mask_nxt;
    start_r            <= start_nxt;
    out_status_r       <= fin_status;
    out_region_start_r <= fin_start;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lim_r       <= CFG_W'(MAP_BITS);
      word_vld_r  <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      // saturate the map size to the physical map
      if (cfg_valid && cfg_ready) begin
        if (cfg_map_bits_in_use > CFG_W'(MAP_BITS)) begin
          lim_r <= CFG_W'(MAP_BITS);
        end else begin
          lim_r <= cfg_map_bits_in_use;
        end
      end
      if (ram_wr_en) begin
        word_vld_r[w_r] <= 1'b1;
      end
      if (ram_rd_en) begin
        rd_vld_r <= word_vld_r[ram_rd_addr];
      end
    end
  end

`ifndef ASSERT_OFF
  // A result only follows an accepted request or work in progress.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n)) |-> $past((state_r != S_IDLE) || start))
    else $error("result strobe without a request");

  // Only a successful find reports a start position.
  a_start_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_region_start == '0))
    else $error("region start set on a failed request");

  // Leaving the busy state always delivers a result.
  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("request dropped without a result");

  // Write-back never runs past the last word of the region.
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (w_r <= end_r))
    else $error("write-back beyond region end");
`endif

endmodule

`default_nettype wire

[hdl/arba_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered and held when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
